[rtl/hcbp_pkg.sv]
// Shared widths, default parameter values and command codes of the code bit packer.
package hcbp_pkg;

	// Field widths of the request and result channels.
	localparam int CMD_W    = 2;
	localparam int SYM_W    = 8;
	localparam int CODE_W   = 32;
	localparam int LEN_IN_W = 6;
	localparam int BYTE_W   = 8;
	localparam int VBITS_W  = 4;

	// Pending bits never reach a full byte, so seven of them are kept.
	localparam int PEND_W  = BYTE_W - 1;
	localparam int COUNT_W = 3;

	// Defaults of the top level parameters.
	localparam int MAX_CODE_LEN_DEF  = 32;
	localparam int ALPHABET_SIZE_DEF = 256;

	// Request commands.
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

endpackage

[rtl/hcbp_req_if.sv]
// Request channel: command, symbol and code fields with a valid/ready handshake.
interface hcbp_req_if;
	import hcbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [SYM_W-1:0]    symbol;
	logic [CODE_W-1:0]   code_value;
	logic [LEN_IN_W-1:0] code_length;

	modport source (output valid, command, symbol, code_value, code_length, input ready);
	modport sink   (input valid, command, symbol, code_value, code_length, output ready);

endinterface

[rtl/hcbp_res_if.sv]
// Result channel: packed byte, its valid bit count and the last marker.
interface hcbp_res_if;
	import hcbp_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  out_byte;
	logic [VBITS_W-1:0] valid_bits;
	logic               last;

	modport source (output valid, out_byte, valid_bits, last, input ready);
	modport sink   (input valid, out_byte, valid_bits, last, output ready);

endinterface

[rtl/hcbp_code_table.sv]
// Code table memory: one write port and one registered read port.
module hcbp_code_table #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 38
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/hcbp_shift_unit.sv]
// Shared left barrel shifter used for code placement and for byte extraction.
module hcbp_shift_unit #(
	parameter int W    = 40,
	parameter int SH_W = 6
) (
	input  logic [W-1:0]    data,
	input  logic [SH_W-1:0] amount,
	output logic [W-1:0]    result
);

	assign result = data << amount;

endmodule

[rtl/huffman_code_bit_packer_unit.sv]
// Top level of the prefix code bit packer: request decode, sequencer and result register.
//
// The block packs variable-length prefix codes, first bit in the most significant
// position, into bytes. Requests arrive on req, results leave on res; both use
// valid/ready and move one request or one result per handshake.
// A load request writes one code table entry. An encode request reads its entry
// in the accept cycle, places the code behind the pending bits in the following
// cycle, then hands out one full byte per cycle through the result register while
// it can take one, and finally stores the leftover bits. An encode gives at most
// (MAX_CODE_LEN + 7) / 8 bytes, four for 32-bit codes. The byte rate is set by
// the single shared shifter, which moves the accumulator one byte per cycle while
// the result register can take a byte. A flush gives one result when bits are
// pending. req.ready is high only while the sequencer is idle.
// A stalled receiver holds the result register; the sequencer waits for it and
// takes no request until the current one has left all its bytes.
// Reset clears the pending bits, the sequencer and the result valid flag. The code
// table is not cleared: an entry must be loaded before it is encoded.
module huffman_code_bit_packer_unit #(
	parameter int MAX_CODE_LEN  = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hcbp_req_if.sink   req,
	hcbp_res_if.source res
);
	import hcbp_pkg::*;

	// The accumulator holds the pending bits, the code and one spare bit so that
	// a byte can always be taken from its top.
	localparam int CW     = MAX_CODE_LEN;
	localparam int ACC_W  = CW + BYTE_W;
	localparam int LEN_W  = $clog2(CW + 1);
	localparam int SH_W   = $clog2(ACC_W + 1);
	localparam int REM_W  = $clog2(ACC_W);
	localparam int AW     = $clog2(ALPHABET_SIZE);
	localparam int DATA_W = LEN_W + CODE_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LOOKUP = 4'b0010,
		S_EMIT   = 4'b0100,
		S_FLUSH  = 4'b1000
	} state_t;

	state_t state_q;

	logic [PEND_W-1:0]  pending_q;
	logic [COUNT_W-1:0] count_q;
	logic [ACC_W-1:0]   acc_q;
	logic [REM_W-1:0]   rem_q;

	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic [VBITS_W-1:0] out_bits_q;
	logic               out_last_q;

	logic              req_hs;
	logic              sym_ok;
	logic [LEN_W-1:0]  len_sat;
	logic              wr_en;
	logic              rd_en;
	logic [DATA_W-1:0] wr_data;
	logic [DATA_W-1:0] rd_data;
	logic [LEN_W-1:0]  rd_len;
	logic [CW-1:0]     code_mask;
	logic [CW-1:0]     rd_code;
	logic [ACC_W-1:0]  sh_data;
	logic [SH_W-1:0]   sh_amount;
	logic [ACC_W-1:0]  sh_result;
	logic              out_free;
	logic              emit_go;
	logic              emit_last;

	// Request decode.
	assign req.ready = (state_q == S_IDLE);
	assign req_hs    = req.valid && req.ready;
	assign sym_ok    = {1'b0, req.symbol} < (SYM_W + 1)'(ALPHABET_SIZE);

	// Lengths above the longest supported code are saturated when stored.
	assign len_sat = (req.code_length > LEN_IN_W'(CW)) ? LEN_W'(CW) : LEN_W'(req.code_length);
	assign wr_en   = req_hs && (req.command == CMD_LOAD) && sym_ok;
	assign rd_en   = req_hs && (req.command == CMD_ENCODE) && sym_ok;
	assign wr_data = {len_sat, req.code_value};

	hcbp_code_table #(
		.DEPTH  (ALPHABET_SIZE),
		.DATA_W (DATA_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (req.symbol[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (req.symbol[AW-1:0]),
		.rd_data (rd_data)
	);

	// Code bits above the stored length are cleared so that they cannot land on
	// the pending bits once the code is lifted.
	assign rd_len    = rd_data[DATA_W-1 -: LEN_W];
	assign code_mask = ~({CW{1'b1}} << rd_len);
	assign rd_code   = CW'(rd_data[CODE_W-1:0]) & code_mask;

	// In the lookup cycle the shifter lifts the code so that its first bit sits
	// right behind the pending bits. While bytes are handed out it moves the
	// accumulator up by one byte.
	always_comb begin
		if (state_q == S_LOOKUP) begin
			sh_data   = ACC_W'(rd_code);
			sh_amount = SH_W'(ACC_W) - SH_W'(count_q) - SH_W'(rd_len);
		end else begin
			sh_data   = acc_q;
			sh_amount = SH_W'(BYTE_W);
		end
	end

	hcbp_shift_unit #(
		.W    (ACC_W),
		.SH_W (SH_W)
	) u_shift (
		.data   (sh_data),
		.amount (sh_amount),
		.result (sh_result)
	);

	// The result register can take a byte when it is empty or being drained.
	assign out_free  = !out_valid_q || res.ready;
	assign emit_go   = (state_q == S_EMIT) && (rem_q >= REM_W'(BYTE_W)) && out_free;
	assign emit_last = (REM_W + 1)'(rem_q) < (REM_W + 1)'(2 * BYTE_W);

	// Sequencer and pending bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pending_q <= '0;
			count_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rd_en) begin
						state_q <= S_LOOKUP;
					end else if (req_hs && (req.command == CMD_FLUSH) && (count_q != '0)) begin
						state_q <= S_FLUSH;
					end
				end
				S_LOOKUP: begin
					// A zero-length code appends nothing.
					state_q <= (rd_len == '0) ? S_IDLE : S_EMIT;
				end
				S_EMIT: begin
					if (rem_q < REM_W'(BYTE_W)) begin
						pending_q <= acc_q[ACC_W-1 -: PEND_W];
						count_q   <= rem_q[COUNT_W-1:0];
						state_q   <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pending_q <= '0;
						count_q   <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Accumulator and remaining bit count.
	always_ff @(posedge clk) begin
		if ((state_q == S_LOOKUP) && (rd_len != '0)) begin
			acc_q <= sh_result | {pending_q, (ACC_W - PEND_W)'(0)};
			rem_q <= REM_W'(count_q) + REM_W'(rd_len);
		end else if (emit_go) begin
			acc_q <= sh_result;
			rem_q <= rem_q - REM_W'(BYTE_W);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go || ((state_q == S_FLUSH) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_byte_q <= acc_q[ACC_W-1 -: BYTE_W];
			out_bits_q <= VBITS_W'(BYTE_W);
			out_last_q <= emit_last;
		end else if ((state_q == S_FLUSH) && out_free) begin
			out_byte_q <= {pending_q, 1'b0};
			out_bits_q <= VBITS_W'(count_q);
			out_last_q <= 1'b1;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_byte   = out_byte_q;
	assign res.valid_bits = out_bits_q;
	assign res.last       = out_last_q;

	// Bits below the pending count are always zero, so a flush pads with zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		PEND_W'(pending_q << count_q) == '0)
		else $error("pending bits hold data below the pending count");

	// The byte marked last leaves fewer than eight bits behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && emit_last |=> rem_q < REM_W'(BYTE_W))
		else $error("full byte left after the last byte of an encode");

	// A flush only waits in its state while bits are pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> (count_q != '0))
		else $error("flush state entered with no pending bits");

	// A table read is always followed by the lookup cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == S_LOOKUP))
		else $error("table read without lookup cycle");

endmodule

[tb/sv/hcbp_checker.sv]
// Scoreboard for the code bit packer: predicts the packed bytes of every request and checks each result.
`timescale 1ns / 1ps
module hcbp_checker #(
	parameter int MAX_CODE_LEN  = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	hcbp_req_if  req,
	hcbp_res_if  res,
	output int   fail_count,
	output int   owed,
	output int   bytes_checked
);
	import hcbp_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic [VBITS_W-1:0] nbits;
		logic               last;
	} packed_byte_t;

	// Local copy of the code table and the partial byte.
	logic [CODE_W-1:0]   code_table [ALPHABET_SIZE];
	logic [LEN_IN_W-1:0] len_table  [ALPHABET_SIZE];
	logic [PEND_W-1:0]   pend_bits;
	logic [COUNT_W-1:0]  pend_cnt;

	packed_byte_t owed_bytes [$];
	packed_byte_t got;
	packed_byte_t want;

	initial begin
		fail_count    = 0;
		owed          = 0;
		bytes_checked = 0;
	end

	task automatic pack_request(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_IN_W-1:0] len);
		logic [63:0]  acc;
		logic [63:0]  mask;
		int           total;
		int           l;
		packed_byte_t b;
		case (cmd)
		CMD_LOAD: begin
			// Symbols outside the alphabet are ignored by load and encode.
			if (sym < ALPHABET_SIZE) begin
				code_table[sym] = code;
				len_table[sym]  = (len > MAX_CODE_LEN) ? LEN_IN_W'(MAX_CODE_LEN) : len;
			end
		end
		CMD_ENCODE: begin
			if (sym < ALPHABET_SIZE)
				l = len_table[sym];
			else
				l = 0;
			if (l != 0) begin
				mask  = (64'd1 << l) - 64'd1;
				acc   = (64'(pend_bits) << l) | (64'(code_table[sym]) & mask);
				total = pend_cnt + l;
				while (total >= BYTE_W) begin
					total  -= BYTE_W;
					b.data  = BYTE_W'(acc >> total);
					b.nbits = VBITS_W'(BYTE_W);
					b.last  = (total < BYTE_W);
					owed_bytes.push_back(b);
				end
				pend_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
				pend_cnt  = COUNT_W'(total);
			end
		end
		CMD_FLUSH: begin
			if (pend_cnt != 0) begin
				b.data  = BYTE_W'({1'b0, pend_bits} << (BYTE_W - pend_cnt));
				b.nbits = VBITS_W'(pend_cnt);
				b.last  = 1'b1;
				owed_bytes.push_back(b);
				pend_bits = '0;
				pend_cnt  = '0;
			end
		end
		default: ;
		endcase
	endtask

	task automatic log_mismatch(input string why, input packed_byte_t exp_b, input packed_byte_t act_b);
		if (fail_count < 10)
			$display("[%0t] %s: expected byte %h bits %0d last %b, got byte %h bits %0d last %b",
				$realtime, why, exp_b.data, exp_b.nbits, exp_b.last,
				act_b.data, act_b.nbits, act_b.last);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits = '0;
			pend_cnt  = '0;
			owed_bytes.delete();
			owed = 0;
		end else begin
			if (res.valid && res.ready) begin
				got = {res.out_byte, res.valid_bits, res.last};
				if (owed_bytes.size() == 0) begin
					log_mismatch("result with nothing owed", '0, got);
				end else begin
					want = owed_bytes.pop_front();
					if (got.data !== want.data || got.nbits !== want.nbits
							|| got.last !== want.last)
						log_mismatch("result mismatch", want, got);
				end
				bytes_checked++;
			end
			if (req.valid && req.ready)
				pack_request(req.command, req.symbol, req.code_value, req.code_length);
			owed = owed_bytes.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
// Top of the code bit packer testbench: clock, reset, request and result drivers, verdict.
`timescale 1ns / 1ps
module tb_top;
	import hcbp_pkg::*;

	// Command 3 has no meaning; the block must swallow it without a result.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int RANDOM_REQUESTS = 460;
	localparam int MAX_IDLE        = 14;
	// Extra wait after the last owed byte, so that any work still in flight shows up.
	localparam int DRAIN_CYCLES    = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hcbp_req_if req ();
	hcbp_res_if res ();

	int fail_count;
	int owed;
	int bytes_checked;

	// When set, the matching side runs without idle cycles. Both flags flip now
	// and then so that long back-to-back stretches alternate with gappy ones.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	// Symbols whose table entry has been written; only these are ever encoded,
	// since the table holds garbage until a load reaches it.
	bit sym_loaded [256];
	logic [SYM_W-1:0] loaded_syms [$];

	int n_load;
	int n_encode;
	int n_flush;
	int n_unused;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	huffman_code_bit_packer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	hcbp_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.res           (res),
		.fail_count    (fail_count),
		.owed          (owed),
		.bytes_checked (bytes_checked)
	);

	// Present one request after a random number of idle cycles and hold it until the
	// block takes it. Called at a falling edge and returns at a falling edge, so valid
	// is only lowered when a gap really follows.
	task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_IN_W-1:0] len);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.command     <= cmd;
		req.symbol      <= sym;
		req.code_value  <= code;
		req.code_length <= len;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		case (cmd)
		CMD_LOAD:   n_load++;
		CMD_ENCODE: n_encode++;
		CMD_FLUSH:  n_flush++;
		default:    n_unused++;
		endcase
		if ($urandom_range(0, 24) == 0)
			tx_steady = !tx_steady;
	endtask

	task automatic load_code(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
			input logic [LEN_IN_W-1:0] len);
		issue_request(CMD_LOAD, sym, code, len);
		if (!sym_loaded[sym]) begin
			sym_loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	// The code fields are don't-care on encode and flush; they carry noise on purpose.
	task automatic encode_symbol(input logic [SYM_W-1:0] sym);
		issue_request(CMD_ENCODE, sym, $urandom(), LEN_IN_W'($urandom()));
	endtask

	task automatic flush_pending();
		issue_request(CMD_FLUSH, SYM_W'($urandom()), $urandom(), LEN_IN_W'($urandom()));
	endtask

	// Draws a code length: mostly short codes as a real prefix code would have,
	// some long ones up to the limit, a few overlong ones and a few empty ones.
	function automatic logic [LEN_IN_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return LEN_IN_W'($urandom_range(1, 8));
		else if (r < 80)
			return LEN_IN_W'($urandom_range(9, 16));
		else if (r < 92)
			return LEN_IN_W'($urandom_range(17, 32));
		else if (r < 96)
			return LEN_IN_W'($urandom_range(33, 63));
		return '0;
	endfunction

	// Result side: stall a random number of cycles before each result, then wait for it.
	initial begin
		int stall;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res.valid);
			if ($urandom_range(0, 24) == 0)
				rx_steady = !rx_steady;
		end
	end

	initial begin
		int r;
		int done;
		req.valid       = 1'b0;
		req.command     = CMD_LOAD;
		req.symbol      = '0;
		req.code_value  = '0;
		req.code_length = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Table entries cover the longest code, a one-bit code,
		// lengths past the limit (they saturate to 32), an empty code and a code
		// whose value has bits set above its length.
		load_code(8'd0,   32'hFFFF_FFFF, 6'd32);
		load_code(8'd255, 32'h0000_0000, 6'd1);
		load_code(8'd1,   32'h0000_00A5, 6'd63);
		load_code(8'd2,   $urandom(),    6'd0);
		load_code(8'd3,   32'hFFFF_FFFE, 6'd3);
		load_code(8'd4,   32'h8000_0005, 6'd33);
		// Nothing is pending yet, so this flush must not produce a byte.
		flush_pending();
		// Four pending bits followed by a full 32-bit code: four bytes, four left.
		encode_symbol(8'd255);
		encode_symbol(8'd3);
		encode_symbol(8'd0);
		// An empty code and an unknown command leave the pending bits alone.
		encode_symbol(8'd2);
		issue_request(CMD_UNUSED, SYM_W'($urandom()), $urandom(), LEN_IN_W'($urandom()));
		flush_pending();
		// A byte-aligned 32-bit code with nothing pending.
		encode_symbol(8'd1);
		// Seven pending bits plus 32 fill four bytes and leave seven for a flush.
		encode_symbol(8'd3);
		encode_symbol(8'd3);
		encode_symbol(8'd255);
		encode_symbol(8'd0);
		flush_pending();
		// A flush of a single bit, then a saturated code with its top bit set.
		encode_symbol(8'd255);
		flush_pending();
		encode_symbol(8'd4);
		flush_pending();

		// Random part: mostly encodes of loaded symbols, with reloads of the
		// table, flushes at random points and the odd unknown command. Unknown
		// commands do not count toward the request total.
		done = 0;
		while (done < RANDOM_REQUESTS) begin
			r = $urandom_range(0, 99);
			if (r < 14 || loaded_syms.size() == 0) begin
				load_code(SYM_W'($urandom()), $urandom(), pick_length());
				done++;
			end else if (r < 78) begin
				encode_symbol(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
				done++;
			end else if (r < 95) begin
				flush_pending();
				done++;
			end else begin
				issue_request(CMD_UNUSED, SYM_W'($urandom()), $urandom(),
					LEN_IN_W'($urandom()));
			end
		end
		req.valid <= 1'b0;

		// Let every owed byte arrive, then give the block time to show any extra one.
		while (owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d loads, %0d encodes, %0d flushes and %0d unknown commands.",
			n_load, n_encode, n_flush, n_unused);
		$display("Compared %0d result bytes; %0d mismatches, %0d bytes still owed.",
			bytes_checked, fail_count, owed);
		if (fail_count == 0 && owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: the slowest legal run needs well under a millisecond.
	initial begin
		#5_000_000;
		$display("Timeout with %0d bytes still owed.", owed);
		$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/hcbp_pkg.sv
rtl/hcbp_req_if.sv
rtl/hcbp_res_if.sv
rtl/hcbp_code_table.sv
rtl/hcbp_shift_unit.sv
rtl/huffman_code_bit_packer_unit.sv
tb/sv/hcbp_checker.sv
tb/sv/tb_top.sv
